// ----- hw/rtl/sfxc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfxc_pkg
// Shared constants and types for the SPI frame slave with XOR check.
// ----------------------------------------------------------------------------
package sfxc_pkg;

  // Default payload length in 32-bit words (1 to 3)
  localparam int PAYLOAD_WORDS_DEF = 3;
  localparam int MAX_PAYLOAD_BYTES = 12;

  localparam int BYTE_W   = 8;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 32;
  localparam int APB_DW   = 64;
  localparam int APB_AW   = 5;

  // Register index, taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_MASTER_HEADER = 2'd0,
    REG_SLAVE_HEADER  = 2'd1,
    REG_REPLY_LOW     = 2'd2,
    REG_REPLY_HIGH    = 2'd3
  } reg_index_t;

endpackage

// ----- hw/rtl/spi_frame_slave_xor_check_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_frame_slave_xor_check_unit
// Byte-wise SPI slave framer: header hunt, payload capture, XOR check and
// reply byte generation.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one received SPI byte per word. For every accepted word one
//   result word leaves on m_*: the reply byte to load for the next transfer,
//   m_tlast when the byte closed a frame, m_tuser when that frame checked,
//   plus the last good payload and the good/bad frame counters.
//   Configure the headers and the reply payload over APB while no word is
//   in flight; reads return the register contents.
//   A taken word passes the input register, then the result register,
//   before its result shows on m_*. Throughput is one word per cycle while
//   the receiver keeps m_tready high; the whole frame update (position,
//   running XOR, compare, latch) is one combinational pass between the two
//   registers.
//   When the receiver stalls, the result register holds and the input
//   register takes at most one more word, then s_tready drops.
//   Reset clears the frame tracker, the counters, the latched payload and
//   all configuration registers to zero.
// ----------------------------------------------------------------------------
module spi_frame_slave_xor_check_unit
  import sfxc_pkg::*;
#(
  parameter int PAYLOAD_WORDS = PAYLOAD_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] rx_byte
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  // [7:0] tx_byte, [71:8] payload_low, [103:72] payload_high,
  // [135:104] good_frames, [167:136] bad_frames
  output logic [167:0]      m_tdata,
  output logic              m_tlast,   // frame_done
  output logic              m_tuser,   // frame_ok
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int PAYLOAD_BYTES = 4 * PAYLOAD_WORDS;
  localparam int FRAME_LEN     = PAYLOAD_BYTES + 2;
  localparam int IDX_W         = $clog2(PAYLOAD_BYTES);
  localparam logic [POS_W-1:0] PB_POS    = POS_W'(PAYLOAD_BYTES);
  localparam logic [POS_W:0]   FRAME_POS = (POS_W + 1)'(FRAME_LEN);

  // configuration registers
  logic [BYTE_W-1:0] master_header;
  logic [BYTE_W-1:0] slave_header;
  logic [63:0]       reply_low;
  logic [31:0]       reply_high;

  reg_index_t reg_sel;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[4:3]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      master_header <= '0;
      slave_header  <= '0;
      reply_low     <= '0;
      reply_high    <= '0;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_MASTER_HEADER: master_header <= pwdata[7:0];
        REG_SLAVE_HEADER:  slave_header  <= pwdata[7:0];
        REG_REPLY_LOW:     reply_low     <= pwdata;
        REG_REPLY_HIGH:    reply_high    <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MASTER_HEADER: prdata = {56'd0, master_header};
      REG_SLAVE_HEADER:  prdata = {56'd0, slave_header};
      REG_REPLY_LOW:     prdata = reply_low;
      REG_REPLY_HIGH:    prdata = {32'd0, reply_high};
      default:           prdata = '0;
    endcase
  end

  // input register
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              advance;

  // result slot is free or draining this cycle
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  // frame tracker state
  logic              frame_active;
  logic [POS_W-1:0]  byte_pos;
  logic [BYTE_W-1:0] run_xor;
  logic [BYTE_W-1:0] rx_buf       [PAYLOAD_BYTES];
  logic [BYTE_W-1:0] good_payload [PAYLOAD_BYTES];
  logic [COUNT_W-1:0] good_count;
  logic [COUNT_W-1:0] bad_count;

  logic              frame_active_next;
  logic [POS_W-1:0]  byte_pos_next;
  logic [BYTE_W-1:0] run_xor_next;
  logic [COUNT_W-1:0] good_count_next;
  logic [COUNT_W-1:0] bad_count_next;
  logic              buf_write;
  logic [POS_W-1:0]  buf_idx;
  logic              done;
  logic              ok;
  logic [POS_W-1:0]  tx_pos;
  logic [POS_W:0]    pos_inc;
  logic [BYTE_W-1:0] tx_byte;
  logic [95:0]       payload_vec;

  assign buf_idx = byte_pos - POS_W'(1);
  assign pos_inc = {1'b0, byte_pos} + (POS_W + 1)'(1);

  always_comb begin
    frame_active_next = frame_active;
    byte_pos_next     = byte_pos;
    run_xor_next      = run_xor;
    good_count_next   = good_count;
    bad_count_next    = bad_count;
    buf_write         = 1'b0;
    done              = 1'b0;
    ok                = 1'b0;
    tx_pos            = '0;
    if (!frame_active) begin
      // hunt for the master header; anything else is dropped
      if (in_byte == master_header) begin
        frame_active_next = 1'b1;
        byte_pos_next     = POS_W'(1);
        run_xor_next      = in_byte;
        tx_pos            = POS_W'(1);
      end
    end else begin
      if (byte_pos >= POS_W'(1) && byte_pos <= PB_POS) begin
        buf_write    = 1'b1;
        run_xor_next = run_xor ^ in_byte;
      end
      if (pos_inc < FRAME_POS) begin
        byte_pos_next = pos_inc[POS_W-1:0];
        tx_pos        = pos_inc[POS_W-1:0];
      end else begin
        // checksum byte: compare, count, restart the hunt
        done = 1'b1;
        ok   = (run_xor_next == in_byte);
        if (ok) begin
          good_count_next = good_count + COUNT_W'(1);
        end else begin
          bad_count_next = bad_count + COUNT_W'(1);
        end
        frame_active_next = 1'b0;
        byte_pos_next     = '0;
        run_xor_next      = '0;
      end
    end
  end

  sfxc_reply #(
    .PAYLOAD_WORDS(PAYLOAD_WORDS)
  ) u_reply (
    .pos         (tx_pos),
    .slave_header(slave_header),
    .reply_low   (reply_low),
    .reply_high  (reply_high),
    .tx_byte     (tx_byte)
  );

  logic step;
  assign step = advance && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active <= 1'b0;
      byte_pos     <= '0;
      run_xor      <= '0;
      good_count   <= '0;
      bad_count    <= '0;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
        good_payload[i] <= '0;
      end
    end else if (step) begin
      frame_active <= frame_active_next;
      byte_pos     <= byte_pos_next;
      run_xor      <= run_xor_next;
      good_count   <= good_count_next;
      bad_count    <= bad_count_next;
      if (done && ok) begin
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
          good_payload[i] <= rx_buf[i];
        end
      end
    end
  end

  // receive buffer holds no reset: each entry is written before a latch
  always_ff @(posedge clk) begin
    if (step && buf_write) begin
      rx_buf[buf_idx[IDX_W-1:0]] <= in_byte;
    end
  end

  // payload as it stands after this byte; unused bytes read as zero
  always_comb begin
    payload_vec = '0;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      if (done && ok) begin
        payload_vec[8*i +: 8] = rx_buf[i];
      end else begin
        payload_vec[8*i +: 8] = good_payload[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {bad_count_next, good_count_next, payload_vec[95:64],
                  payload_vec[63:0], tx_byte};
      m_tlast <= done;
      m_tuser <= ok;
    end
  end

endmodule

// ----- hw/rtl/sfxc_reply.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfxc_reply
// Selects the reply frame byte for a given frame position: slave header,
// configured payload byte, or the XOR of header and payload.
// ----------------------------------------------------------------------------
module sfxc_reply
  import sfxc_pkg::*;
#(
  parameter int PAYLOAD_WORDS = PAYLOAD_WORDS_DEF
) (
  input  logic [POS_W-1:0]  pos,
  input  logic [BYTE_W-1:0] slave_header,
  input  logic [63:0]       reply_low,
  input  logic [31:0]       reply_high,
  output logic [BYTE_W-1:0] tx_byte
);

  localparam int PAYLOAD_BYTES = 4 * PAYLOAD_WORDS;
  localparam logic [POS_W-1:0] PB_POS = POS_W'(PAYLOAD_BYTES);

  logic [95:0]       reply_vec;
  logic [BYTE_W-1:0] reply_xor;
  logic [POS_W-1:0]  idx;

  assign reply_vec = {reply_high, reply_low};
  assign idx       = pos - POS_W'(1);

  // XOR over the header and the payload bytes that are actually sent
  always_comb begin
    reply_xor = slave_header;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      reply_xor = reply_xor ^ reply_vec[8*i +: 8];
    end
  end

  always_comb begin
    if (pos == '0) begin
      tx_byte = slave_header;
    end else if (pos <= PB_POS) begin
      tx_byte = reply_vec[{idx, 3'b000} +: 8];
    end else begin
      tx_byte = reply_xor;
    end
  end

endmodule
